[hdl/tcc_pkg.sv]
package tcc_pkg;

  localparam int OUT_BITS = 48;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  // Control that travels beside the divider pipeline.
  typedef struct packed {
    logic valid;
    logic degen;
    logic neg_x;
    logic neg_y;
  } tcc_side_t;

endpackage

[hdl/triangle_circumcenter_core.sv]
// Channel  Dir  Bits              Content
// s_*      in   6*COORD_BITS->B   point0_x..point2_y, COORD_BITS each, lowest first
// m_*      out  104               center_x[47:0], center_y[95:48], status[97:96]
//
// Front stages, then restoring divider stages (one quotient bit each; NW =
// 3*COORD_BITS+6+FRAC_BITS bits, 70 by default), then an output register.
// One transaction per cycle unless m_tready stalls; rst (synchronous) clears
// valid bits only. A stall on m_tready freezes all stages and drops s_tready.
module triangle_circumcenter_core #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // point0_x, point0_y, point1_x, point1_y, point2_x, point2_y
  input  logic [((6*COORD_BITS+7)/8)*8-1:0]     s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // center_x, center_y, status, zero pad
  output logic [103:0]                          m_tdata
);
  import tcc_pkg::*;

  localparam int NW  = 3*COORD_BITS + 6 + FRAC_BITS;  // numerator magnitude
  localparam int DW  = 2*COORD_BITS + 3;              // |D|
  localparam int QEW = NW + OUT_BITS;
  localparam logic [QEW-1:0] LIM = QEW'(1) << (OUT_BITS - 1);

  logic en;
  assign en       = ~m_tvalid | m_tready;
  assign s_tready = en;

  tcc_side_t     side0;
  logic [NW-1:0] mag_x, mag_y, qx, qy;
  logic [DW-1:0] dmag;

  tcc_front #(.C(COORD_BITS), .F(FRAC_BITS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_valid(s_tvalid),
    .in_pts  (s_tdata[6*COORD_BITS-1:0]),
    .side    (side0),
    .mag_x   (mag_x),
    .mag_y   (mag_y),
    .dmag    (dmag)
  );

  tcc_div #(.NW(NW), .DW(DW)) u_div_x (
    .clk(clk), .en(en), .num(mag_x), .den(dmag), .quo(qx)
  );

  tcc_div #(.NW(NW), .DW(DW)) u_div_y (
    .clk(clk), .en(en), .num(mag_y), .den(dmag), .quo(qy)
  );

  // sideband delay matching the divider depth
  tcc_side_t side_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_side
    tcc_side_t sp;
    if (k == 0) begin : g_first
      assign sp = side0;
    end else begin : g_next
      assign sp = side_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        side_r[k].valid <= 1'b0;
      end else if (en) begin
        side_r[k].valid <= sp.valid;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k].degen <= sp.degen;
        side_r[k].neg_x <= sp.neg_x;
        side_r[k].neg_y <= sp.neg_y;
      end
    end
  end

  // sign, saturation and status
  tcc_side_t             st;
  logic [QEW-1:0]        ex, ey;
  logic                  sat_x, sat_y;
  logic [OUT_BITS-1:0]   rx, ry;
  logic [1:0]            status;

  assign st = side_r[NW-1];
  assign ex = QEW'(qx);
  assign ey = QEW'(qy);

  always_comb begin
    sat_x = st.neg_x ? (ex > LIM) : (ex > LIM - QEW'(1));
    sat_y = st.neg_y ? (ey > LIM) : (ey > LIM - QEW'(1));
    if (st.neg_x) begin
      rx = sat_x ? OUT_BITS'(~LIM + QEW'(1)) : OUT_BITS'(~ex + QEW'(1));
    end else begin
      rx = sat_x ? OUT_BITS'(LIM - QEW'(1)) : OUT_BITS'(ex);
    end
    if (st.neg_y) begin
      ry = sat_y ? OUT_BITS'(~LIM + QEW'(1)) : OUT_BITS'(~ey + QEW'(1));
    end else begin
      ry = sat_y ? OUT_BITS'(LIM - QEW'(1)) : OUT_BITS'(ey);
    end
    if (st.degen) begin
      status = ST_DEGEN;
      rx     = '0;
      ry     = '0;
    end else if (sat_x || sat_y) begin
      status = ST_SAT;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= st.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {6'd0, status, ry, rx};
    end
  end

endmodule

[hdl/tcc_front.sv]
module tcc_front #(
  parameter int C = 16,
  parameter int F = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [6*C-1:0]       in_pts,
  output tcc_pkg::tcc_side_t   side,
  output logic [3*C+5+F:0]     mag_x,
  output logic [3*C+5+F:0]     mag_y,
  output logic [2*C+2:0]       dmag
);
  import tcc_pkg::*;

  localparam int PW = 2*C + 2;   // first products
  localparam int DSW = 2*C + 4;  // signed D
  localparam int SW = 2*C + 3;   // squared lengths
  localparam int TW4 = 3*C + 4;  // second products
  localparam int TW5 = 3*C + 6;  // numerators
  localparam int TW = TW5 + F;   // shifted numerators
  localparam int DW = 2*C + 3;   // |D|

  // stage 1: differences
  logic                v1;
  logic signed [C-1:0] x0_1, y0_1;
  logic signed [C:0]   bx_1, by_1, cx_1, cy_1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_1 <= in_pts[0*C +: C];
      y0_1 <= in_pts[1*C +: C];
      bx_1 <= (C+1)'($signed(in_pts[2*C +: C])) - (C+1)'($signed(in_pts[0*C +: C]));
      by_1 <= (C+1)'($signed(in_pts[3*C +: C])) - (C+1)'($signed(in_pts[1*C +: C]));
      cx_1 <= (C+1)'($signed(in_pts[4*C +: C])) - (C+1)'($signed(in_pts[0*C +: C]));
      cy_1 <= (C+1)'($signed(in_pts[5*C +: C])) - (C+1)'($signed(in_pts[1*C +: C]));
    end
  end

  // stage 2: cross and square products
  logic                 v2;
  logic signed [C-1:0]  x0_2, y0_2;
  logic signed [C:0]    bx_2, by_2, cx_2, cy_2;
  logic signed [PW-1:0] bxcy, bycx, bxbx, byby, cxcx, cycy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_2 <= x0_1;
      y0_2 <= y0_1;
      bx_2 <= bx_1;
      by_2 <= by_1;
      cx_2 <= cx_1;
      cy_2 <= cy_1;
      bxcy <= bx_1 * cy_1;
      bycx <= by_1 * cx_1;
      bxbx <= bx_1 * bx_1;
      byby <= by_1 * by_1;
      cxcx <= cx_1 * cx_1;
      cycy <= cy_1 * cy_1;
    end
  end

  // stage 3: D, |b|^2, |c|^2
  logic                  v3;
  logic signed [C-1:0]   x0_3, y0_3;
  logic signed [C:0]     bx_3, by_3, cx_3, cy_3;
  logic signed [DSW-1:0] d_3;
  logic signed [SW-1:0]  bb_3, cc_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_3 <= x0_2;
      y0_3 <= y0_2;
      bx_3 <= bx_2;
      by_3 <= by_2;
      cx_3 <= cx_2;
      cy_3 <= cy_2;
      d_3  <= (DSW'(bxcy) - DSW'(bycx)) <<< 1;
      bb_3 <= SW'(bxbx) + SW'(byby);
      cc_3 <= SW'(cxcx) + SW'(cycy);
    end
  end

  // stage 4: numerator terms
  logic                  v4;
  logic signed [DSW-1:0] d_4;
  logic signed [TW4-1:0] x0d, cybb, bycc, y0d, bxcc, cxbb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_4  <= d_3;
      x0d  <= x0_3 * d_3;
      cybb <= cy_3 * bb_3;
      bycc <= by_3 * cc_3;
      y0d  <= y0_3 * d_3;
      bxcc <= bx_3 * cc_3;
      cxbb <= cx_3 * bb_3;
    end
  end

  // stage 5: numerator sums
  logic                  v5;
  logic signed [DSW-1:0] d_5;
  logic signed [TW5-1:0] tx_5, ty_5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_5  <= d_4;
      tx_5 <= TW5'(x0d) + TW5'(cybb) - TW5'(bycc);
      ty_5 <= TW5'(y0d) + TW5'(bxcc) - TW5'(cxbb);
    end
  end

  // stage 6: magnitudes and signs for the divider
  logic signed [TW-1:0] tx_s, ty_s;
  logic                 dneg;

  assign tx_s = TW'(tx_5) <<< F;
  assign ty_s = TW'(ty_5) <<< F;
  assign dneg = d_5[DSW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      side.valid <= 1'b0;
    end else if (en) begin
      side.valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side.degen <= (d_5 == '0);
      side.neg_x <= tx_s[TW-1] ^ dneg;
      side.neg_y <= ty_s[TW-1] ^ dneg;
      mag_x      <= tx_s[TW-1] ? (~tx_s + TW'(1)) : tx_s;
      mag_y      <= ty_s[TW-1] ? (~ty_s + TW'(1)) : ty_s;
      dmag       <= dneg ? DW'(~d_5 + DSW'(1)) : DW'(d_5);
    end
  end

endmodule

[hdl/tcc_div.sv]
module tcc_div #(
  parameter int NW = 70,
  parameter int DW = 35
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  // one restoring step per stage, most significant numerator bit first
  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] num_r [NW];
  logic [NW-1:0] q_r   [NW];
  logic [DW-1:0] den_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [DW-1:0] rp, dp;
    logic [NW-1:0] np, qp;
    logic [DW:0]   trial;
    logic          fits;

    if (k == 0) begin : g_first
      assign rp = '0;
      assign np = num;
      assign qp = '0;
      assign dp = den;
    end else begin : g_next
      assign rp = rem_r[k-1];
      assign np = num_r[k-1];
      assign qp = q_r[k-1];
      assign dp = den_r[k-1];
    end

    assign trial = {rp, np[NW-1]};
    assign fits  = (trial >= {1'b0, dp});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= fits ? DW'(trial - {1'b0, dp}) : DW'(trial);
        num_r[k] <= {np[NW-2:0], 1'b0};
        q_r[k]   <= {qp[NW-2:0], fits};
        den_r[k] <= dp;
      end
    end
  end

  assign quo = q_r[NW-1];

endmodule

[test/tcc_checker.sv]
module tcc_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [95:0]  s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [103:0] m_tdata,
  output int           fail_count,
  output int           pending,
  output int           n_results,
  output int           n_degen,
  output int           n_sat
);
  timeunit 1ns;
  timeprecision 1ps;
  import tcc_pkg::*;

  // packed from the top bit down: status[97:96], cy[95:48], cx[47:0]
  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] cy;
    logic [47:0] cx;
  } center_t;

  localparam logic signed [127:0] OUT_MAX = (128'sd1 <<< (OUT_BITS - 1)) - 1;
  localparam logic signed [127:0] OUT_MIN = -(128'sd1 <<< (OUT_BITS - 1));

  center_t centers_due[$];

  // Clamp a 128-bit quotient to the 48-bit result range.
  function automatic logic [47:0] clamp48(logic signed [127:0] q, inout logic sat);
    if (q > OUT_MAX) begin
      sat = 1'b1;
      return OUT_MAX[47:0];
    end
    if (q < OUT_MIN) begin
      sat = 1'b1;
      return OUT_MIN[47:0];
    end
    return q[47:0];
  endfunction

  // Exact determinant form of the circumcenter, quotients truncated toward zero.
  function automatic center_t solve_center(logic [95:0] pts);
    logic signed [127:0] x0, y0, bx, by, cx, cy, d, bb, cc, tx, ty;
    logic sat;
    center_t r;
    x0 = $signed(pts[15:0]);
    y0 = $signed(pts[31:16]);
    bx = $signed(pts[47:32]) - x0;
    by = $signed(pts[63:48]) - y0;
    cx = $signed(pts[79:64]) - x0;
    cy = $signed(pts[95:80]) - y0;
    d  = 2 * (bx * cy - by * cx);
    sat = 1'b0;
    if (d == 0) begin
      r.cx = '0;
      r.cy = '0;
      r.status = ST_DEGEN;
      return r;
    end
    bb = bx * bx + by * by;
    cc = cx * cx + cy * cy;
    tx = (x0 * d + cy * bb - by * cc) <<< FRAC_BITS;
    ty = (y0 * d + bx * cc - cx * bb) <<< FRAC_BITS;
    r.cx = clamp48(tx / d, sat);
    r.cy = clamp48(ty / d, sat);
    r.status = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  task automatic report(string what, logic [47:0] got, logic [47:0] want);
    $display("mismatch at %0t: result %0d %s got %h want %h",
             $realtime, n_results, what, got, want);
    fail_count++;
  endtask

  assign pending = centers_due.size();

  initial begin
    fail_count = 0;
    n_results  = 0;
    n_degen    = 0;
    n_sat      = 0;
  end

  always @(posedge clk) begin
    center_t got, want;
    if (!rst) begin
      if (s_tvalid && s_tready) centers_due.push_back(solve_center(s_tdata));
      if (m_tvalid && m_tready) begin
        got = m_tdata[97:0];
        if (centers_due.size() == 0) begin
          $display("unexpected result transaction at %0t", $realtime);
          fail_count++;
        end else begin
          want = centers_due.pop_front();
          if (got.cx != want.cx) report("center_x", got.cx, want.cx);
          if (got.cy != want.cy) report("center_y", got.cy, want.cy);
          if (got.status != want.status) begin
            report("status", 48'(got.status), 48'(want.status));
          end
          if (want.status == ST_DEGEN) n_degen++;
          if (want.status == ST_SAT) n_sat++;
        end
        n_results++;
      end
    end
  end

endmodule

[test/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1030;
  localparam int IDLE_LIMIT   = 20000;  // cycles with no transaction at all
  localparam int DRAIN_CYCLES = 160;    // pipeline is 7 + 70 deep

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [95:0]  s_tdata;   // point0_x, point0_y, point1_x, point1_y, point2_x, point2_y
  logic         m_tvalid;
  logic         m_tready;
  logic [103:0] m_tdata;   // center_x, center_y, status, zero pad

  int fail_count, pending, n_results, n_degen, n_sat;
  int idle_cycles;
  int burst_left;

  triangle_circumcenter_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  tcc_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending),
    .n_results(n_results), .n_degen(n_degen), .n_sat(n_sat)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver backpressure: mode drawn at random between always ready,
  // coin flip, mostly stalled and a fixed on/off pattern.
  int rx_mode, rx_count;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_mode  <= 0;
      rx_count <= 0;
    end else begin
      rx_count <= rx_count + 1;
      if (rx_count % 200 == 199) rx_mode <= $urandom_range(0, 3);
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= $urandom_range(0, 1);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= (rx_count % 7) < 4;
      endcase
    end
  end

  // Watchdog: no accepted transaction on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("triangle_circumcenter_core test failed");
        $finish;
      end
    end
  end

  function automatic logic [95:0] pack_points(int x0, int y0, int x1, int y1,
                                              int x2, int y2);
    return {y2[15:0], x2[15:0], y1[15:0], x1[15:0], y0[15:0], x0[15:0]};
  endfunction

  // Send one triangle; holds tvalid high across a burst, drops it in gaps.
  task automatic send_triangle(logic [95:0] pts);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= pts;
    forever begin
      @(negedge clk);
      if (s_tready) begin
        @(posedge clk);
        break;
      end
      @(posedge clk);
    end
  endtask

  function automatic int coord();
    return $urandom_range(0, 65535) - 32768;
  endfunction

  // Random triangle: wide random, small coords, near-collinear (far center),
  // or exactly collinear / coincident.
  function automatic logic [95:0] random_triangle();
    int x0, y0, a, b, k, kind;
    kind = $urandom_range(0, 9);
    if (kind < 4) return pack_points(coord(), coord(), coord(), coord(), coord(), coord());
    if (kind < 7) begin
      x0 = coord();
      y0 = coord();
      x0 = x0 / 512;
      y0 = y0 / 512;
      return pack_points(x0, y0, x0 + $urandom_range(0, 40) - 20,
                         y0 + $urandom_range(0, 40) - 20,
                         x0 + $urandom_range(0, 40) - 20,
                         y0 + $urandom_range(0, 40) - 20);
    end
    x0 = $urandom_range(0, 20000) - 32768;
    y0 = $urandom_range(0, 20000) - 32768;
    if (kind < 9) begin
      // b = (a, a+k), c = (2a+1, 2(a+k)+1): tiny determinant
      a = $urandom_range(1000, 10000);
      k = $urandom_range(0, 6) - 3;
      return pack_points(x0, y0, x0 + a, y0 + a + k, x0 + 2 * a + 1, y0 + 2 * (a + k) + 1);
    end
    a = $urandom_range(0, 200) - 100;
    b = $urandom_range(0, 200) - 100;
    k = $urandom_range(0, 8) - 4;
    return pack_points(x0, y0, x0 + a, y0 + b, x0 + k * a, y0 + k * b);
  endfunction

  initial begin
    logic [95:0] directed[$];
    int waited;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // right triangle, center at midpoint of hypotenuse
    directed.push_back(pack_points(0, 0, 4, 0, 0, 6));
    // fractional center, negative coordinates
    directed.push_back(pack_points(-3, -7, 2, -1, -5, 4));
    directed.push_back(pack_points(1, 0, 0, 1, 0, 0));
    // all coordinates at the extremes
    directed.push_back(pack_points(-32768, -32768, 32767, -32768, -32768, 32767));
    directed.push_back(pack_points(32767, 32767, -32768, 32767, 32767, -32768));
    directed.push_back(pack_points(-32768, 32767, 32767, 32767, 0, -32768));
    directed.push_back(pack_points(-32768, -32768, 32767, 32767, -32768, 32767));
    // coincident points, all equal and two equal
    directed.push_back(pack_points(-32768, -32768, -32768, -32768, -32768, -32768));
    directed.push_back(pack_points(5, 9, 5, 9, -2, 3));
    directed.push_back(pack_points(0, 0, 0, 0, 0, 0));
    // collinear, including a line through the extremes
    directed.push_back(pack_points(-32768, -32768, 0, 0, 32767, 32767));
    directed.push_back(pack_points(1, 2, 3, 4, 5, 6));
    // all y equal
    directed.push_back(pack_points(-100, 7, 3, 7, 32767, 7));
    // all x equal
    directed.push_back(pack_points(12, -50, 12, 8, 12, 30000));
    // nearly collinear: center far from the points
    directed.push_back(pack_points(-32768, -32768, 0, 1, 32767, 32767));
    directed.push_back(pack_points(-20000, -20000, -10000, -9999, 1, 2));
    directed.push_back(pack_points(20000, 20000, 10000, 10001, -1, 2));
    // large but in range
    directed.push_back(pack_points(30000, -30000, -29000, -31000, 100, 32000));
    foreach (directed[i]) send_triangle(directed[i]);

    repeat (RANDOM_ITEMS) send_triangle(random_triangle());
    s_tvalid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < IDLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d circumcenters: %0d degenerate, %0d saturated, %0d exact",
             n_results, n_degen, n_sat, n_results - n_degen - n_sat);
    if (fail_count == 0 && pending == 0) begin
      $display("triangle_circumcenter_core test passed");
    end else begin
      $display("%0d mismatches, %0d results still outstanding", fail_count, pending);
      $display("triangle_circumcenter_core test failed");
    end
    $finish;
  end

endmodule
